/* sv/spq_pkg.sv */
package spq_pkg;

	localparam int TagW  = 16;
	localparam int AgeW  = 8;
	localparam int PrioW = 2;
	localparam int OccW  = 5;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic [1:0] TRIAGE_OTHER  = 2'd0;
	localparam logic [1:0] TRIAGE_GREEN  = 2'd1;
	localparam logic [1:0] TRIAGE_YELLOW = 2'd2;
	localparam logic [1:0] TRIAGE_RED    = 2'd3;

	typedef struct packed {
		logic [TagW-1:0]  tag;
		logic [AgeW-1:0]  age;
		logic [PrioW-1:0] prio;
	} entry_t;

	// per-cell controls for one queue operation
	typedef struct packed {
		logic push;         // insert the new item this cycle
		logic pop;          // shift toward the head this cycle
		logic left_before;  // left neighbor stays ahead of the new item
	} cell_ctl_t;

	function automatic logic [PrioW-1:0] triage_prio(input logic [1:0] code);
		logic [PrioW-1:0] p;
		unique case (code)
			TRIAGE_RED:    p = 2'd3;
			TRIAGE_YELLOW: p = 2'd2;
			TRIAGE_GREEN:  p = 2'd1;
			default:       p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

/* sv/spq_cell.sv */
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	input  logic               occupied,
	output spq_pkg::entry_t    entry,
	output logic               ahead
);

	spq_pkg::entry_t entry_q;

	// held entry stays ahead of the new one on lower or equal priority (FIFO on ties)
	assign ahead = occupied && (entry_q.prio <= new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push && !ahead) begin
			entry_q <= ctl.left_before ? new_entry : left_entry;
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* sv/stable_priority_queue_top.sv */
// A result is registered and appears on the master side in the cycle after its item is accepted.
// One push or pop per cycle while the master side takes results; every cell compares against
//   the new item in parallel, so one cell row update per item sets the rate.
// The result register frees itself on take, so a new item enters only when no result waits or the waiting one is taken.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending result;
//   cell contents are not cleared, only the entry count.
module stable_priority_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] record_tag, [23:16] patient_age,
	                               // [25:24] triage_code, [31:26] zero
	input  logic [0:0]  s_tuser,   // [0] opcode (0 push, 1 pop)
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] out_tag, [23:16] out_age,
	                               // [25:24] out_priority, [30:26] occupancy, [31] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	// ---------------- input decode ----------------
	logic                accept;
	spq_pkg::opcode_t    opcode;
	spq_pkg::entry_t     new_entry;

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign opcode   = spq_pkg::opcode_t'(s_tuser[0]);

	assign new_entry.tag  = s_tdata[15:0];
	assign new_entry.age  = s_tdata[23:16];
	assign new_entry.prio = spq_pkg::triage_prio(s_tdata[25:24]);

	// ---------------- occupancy ----------------
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_nxt;
	logic            full;
	logic            empty;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = accept && (opcode == spq_pkg::OP_PUSH) && !full;
	assign do_pop  = accept && (opcode == spq_pkg::OP_POP) && !empty;

	always_comb begin
		count_nxt = count_q;
		if (do_push) begin
			count_nxt = count_q + 1'b1;
		end else if (do_pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// ---------------- cell chain ----------------
	// cell 0 is the head; a push shifts the tail part right, a pop shifts all left
	spq_pkg::entry_t entries [QUEUE_DEPTH];
	logic            ahead   [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::cell_ctl_t ctl;
		spq_pkg::entry_t    left_e;
		spq_pkg::entry_t    right_e;
		logic               occ;

		assign occ      = (CntW'(i) < count_q);
		assign ctl.push = do_push;
		assign ctl.pop  = do_pop;

		if (i == 0) begin : g_head
			assign ctl.left_before = 1'b1;
			assign left_e          = new_entry;
		end else begin : g_body
			assign ctl.left_before = ahead[i-1];
			assign left_e          = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = entries[i];  // vacated slot, content irrelevant
		end else begin : g_mid
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.occupied    (occ),
			.entry       (entries[i]),
			.ahead       (ahead[i])
		);
	end

	// ---------------- result register ----------------
	logic                    out_valid_q;
	spq_pkg::status_t        status_q;
	spq_pkg::entry_t         out_entry_q;
	logic [spq_pkg::OccW-1:0] occ_q;
	logic [CntW+spq_pkg::OccW-1:0] count_ext;

	assign count_ext = {{spq_pkg::OccW{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q       <= count_ext[spq_pkg::OccW-1:0];
			out_entry_q <= '0;
			status_q    <= spq_pkg::ST_OK;
			if (opcode == spq_pkg::OP_PUSH) begin
				if (full) begin
					status_q <= spq_pkg::ST_FULL;
				end
			end else if (empty) begin
				status_q <= spq_pkg::ST_EMPTY;
			end else begin
				out_entry_q <= entries[0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, occ_q, out_entry_q.prio, out_entry_q.age, out_entry_q.tag};

	// ---------------- checks ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == spq_pkg::OP_POP && empty) |=> (m_tuser == spq_pkg::ST_EMPTY))
		else $error("pop on empty queue not flagged");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow the queue");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CntW'(2)) |-> (entries[0].prio <= entries[1].prio))
		else $error("head cells out of priority order");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == spq_pkg::OP_PUSH && full) |=>
		(m_tuser == spq_pkg::ST_FULL && count_q == $past(count_q)))
		else $error("push to full queue not rejected");

endmodule
